FILE: sv/dia_pkg.sv
package dia_pkg;

    localparam int SAMPLER_POOL_MAX  = 2048;
    localparam int RESOURCE_POOL_MAX = 4096;
    localparam int NUM_CONTEXTS      = 4;
    localparam int MAX_SLOTS         = 4;
    localparam int PENDING_DEPTH     = 32;

    localparam int CFG_DW = 13;

    localparam logic [2:0] KIND_BIND       = 3'd0;
    localparam logic [2:0] KIND_UNBIND     = 3'd1;
    localparam logic [2:0] KIND_REGISTER   = 3'd2;
    localparam logic [2:0] KIND_UNREGISTER = 3'd3;
    localparam logic [2:0] KIND_BEGIN      = 3'd4;
    localparam logic [2:0] KIND_RETIRE     = 3'd5;
    localparam logic [2:0] KIND_FLUSH      = 3'd6;
    localparam logic [2:0] KIND_STATS      = 3'd7;

    localparam logic [2:0] VIEW_SAMPLER   = 3'd0;
    localparam logic [2:0] VIEW_IMAGE_UAV = 3'd3;

    localparam logic [2:0] BT_NONE          = 3'd0;
    localparam logic [2:0] BT_SAMPLER       = 3'd1;
    localparam logic [2:0] BT_STORAGE_IMAGE = 3'd4;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN_CTX   = 3'd2;
    localparam logic [2:0] ST_SLOT_ACTIVE   = 3'd3;
    localparam logic [2:0] ST_CONTEXTS_FULL = 3'd4;
    localparam logic [2:0] ST_PENDING_FULL  = 3'd5;

    localparam logic CFG_SAMPLER_CAP  = 1'b0;
    localparam logic CFG_RESOURCE_CAP = 1'b1;

    localparam logic POOL_SAMPLER  = 1'b0;
    localparam logic POOL_RESOURCE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DIV,
        S_SLOT,
        S_WALK,
        S_CFG,
        S_DONE
    } t_state;

endpackage

FILE: sv/descriptor_index_allocator_deferred_free_unit.sv
// begin frame and retire reckon the slot-number remainder first, one bit a cycle;
// retire then walks that one slot, while flush and unregister walk every slot of the context,
// and each active slot walked steps through the pending entries
// one request at a time; a capacity write walks every pending entry before it ends
// reset: synchronous, active low; both free stacks read as full with no clearing pass
// (a low-water mark per stack stands for the untouched descending fill)
module descriptor_index_allocator_deferred_free_unit #(
    parameter int SAMPLER_POOL_MAX  = dia_pkg::SAMPLER_POOL_MAX,
    parameter int RESOURCE_POOL_MAX = dia_pkg::RESOURCE_POOL_MAX,
    parameter int NUM_CONTEXTS      = dia_pkg::NUM_CONTEXTS,
    parameter int MAX_SLOTS         = dia_pkg::MAX_SLOTS,
    parameter int PENDING_DEPTH     = dia_pkg::PENDING_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_kind,
    input  logic [2:0]                i_view_kind,
    input  logic [2:0]                i_binding_type,
    input  logic [11:0]               i_binding_index,
    input  logic [15:0]               i_context_id,
    input  logic [7:0]                i_slot_number,
    input  logic [7:0]                i_slot_count,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [2:0]                o_status,
    output logic [2:0]                o_result_type,
    output logic [11:0]               o_result_index,
    output logic [15:0]               o_new_context_id,
    output logic [12:0]               o_allocated_total,
    output logic [12:0]               o_capacity_total,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [dia_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int TS   = NUM_CONTEXTS * MAX_SLOTS;
    localparam int SCW  = $clog2(SAMPLER_POOL_MAX + 1);
    localparam int RCW  = $clog2(RESOURCE_POOL_MAX + 1);
    localparam int SAW  = $clog2(SAMPLER_POOL_MAX);
    localparam int RAW  = $clog2(RESOURCE_POOL_MAX);
    localparam int CW   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SNW  = $clog2(MAX_SLOTS + 1);
    localparam int GSW  = (TS > 1) ? $clog2(TS) : 1;
    localparam int RMW  = $clog2(TS + 1);
    localparam int PW   = $clog2(PENDING_DEPTH);
    localparam int UW   = $clog2(PENDING_DEPTH + 1);

    dia_pkg::t_state r_state, n_state;

    // pool stacks
    logic [SAW-1:0] mem_s [SAMPLER_POOL_MAX];
    logic [RAW-1:0] mem_r [RESOURCE_POOL_MAX];
    logic [SAW-1:0] r_srd;
    logic [RAW-1:0] r_rrd;
    logic           s_we, rs_we;
    logic [SAW-1:0] s_wa, s_wd;
    logic [RAW-1:0] rs_wa, rs_wd;
    logic [SAW-1:0] s_ra;
    logic [RAW-1:0] rs_ra;

    logic [SCW-1:0] r_scap, n_scap, r_sdepth, n_sdepth, r_slow, n_slow;
    logic [RCW-1:0] r_rcap, n_rcap, r_rdepth, n_rdepth, r_rlow, n_rlow;

    // contexts and slots
    logic           r_cv [NUM_CONTEXTS];
    logic           n_cv [NUM_CONTEXTS];
    logic [15:0]    r_cid [NUM_CONTEXTS];
    logic [15:0]    n_cid [NUM_CONTEXTS];
    logic [SNW-1:0] r_cslots [NUM_CONTEXTS];
    logic [SNW-1:0] n_cslots [NUM_CONTEXTS];
    logic [TS-1:0]  r_active, n_active;
    logic [15:0]    r_next_id, n_next_id;

    // pending releases
    logic                     r_pv [PENDING_DEPTH];
    logic                     n_pv [PENDING_DEPTH];
    logic [2:0]               r_pbt [PENDING_DEPTH];
    logic [2:0]               n_pbt [PENDING_DEPTH];
    logic [11:0]              r_pidx [PENDING_DEPTH];
    logic [11:0]              n_pidx [PENDING_DEPTH];
    logic [RMW-1:0]           r_prem [PENDING_DEPTH];
    logic [RMW-1:0]           n_prem [PENDING_DEPTH];
    logic [PW-1:0]            r_page [PENDING_DEPTH];
    logic [PW-1:0]            n_page [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] r_mask [TS];
    logic [PENDING_DEPTH-1:0] n_mask [TS];
    logic [UW-1:0]            r_used, n_used;

    // request work registers
    logic [2:0]     r_kind, n_kind;
    logic           r_pool, n_pool;
    logic [2:0]     r_status, n_status;
    logic [2:0]     r_rtype, n_rtype;
    logic [11:0]    r_ridx, n_ridx;
    logic [15:0]    r_newid, n_newid;
    logic [CW-1:0]  r_ctx, n_ctx;
    logic [SW-1:0]  r_slot, n_slot;
    logic           r_single, n_single;
    logic [UW-1:0]  r_k, n_k;
    logic [SNW-1:0] r_rem, n_rem;
    logic [7:0]     r_sn, n_sn;
    logic [2:0]     r_dcnt, n_dcnt;
    logic [PW-1:0]  r_cp, n_cp;
    logic           r_cfg_pool, n_cfg_pool;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_ostatus, n_ostatus, r_otype, n_otype;
    logic [11:0] r_oidx, n_oidx;
    logic [15:0] r_onewid, n_onewid;
    logic [12:0] r_oalloc, n_oalloc, r_ocap, n_ocap;

    logic in_acc, cfg_acc;

    assign o_in_stall  = (r_state != dia_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == dia_pkg::S_IDLE) && !i_in_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign s_ra  = SAW'(r_sdepth - SCW'(1));
    assign rs_ra = RAW'(r_rdepth - RCW'(1));

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem_s[s_wa] <= s_wd;
        end
        r_srd <= mem_s[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            mem_r[rs_wa] <= rs_wd;
        end
        r_rrd <= mem_r[rs_ra];
    end

    always_comb begin
        logic [TS-1:0]  slot_en;
        logic [RMW-1:0] act_cnt;
        logic           ci_hit, cf_hit, pf_hit, ak_hit;
        logic [CW-1:0]  ci_idx, cf_idx;
        logic [PW-1:0]  pf_idx, ak_idx, dp;
        logic           push_en, push_s, drop_en, advance;
        logic [11:0]    push_idx;
        logic [31:0]    v32, t32;
        logic [GSW-1:0] gs;
        logic [SNW:0]   dt;
        logic [SNW-1:0] dd;
        logic [7:0]     sc8;
        logic [RMW-1:0] rem_dec;

        n_state    = r_state;
        n_scap     = r_scap;
        n_rcap     = r_rcap;
        n_sdepth   = r_sdepth;
        n_rdepth   = r_rdepth;
        n_slow     = r_slow;
        n_rlow     = r_rlow;
        n_cv       = r_cv;
        n_cid      = r_cid;
        n_cslots   = r_cslots;
        n_active   = r_active;
        n_next_id  = r_next_id;
        n_pv       = r_pv;
        n_pbt      = r_pbt;
        n_pidx     = r_pidx;
        n_prem     = r_prem;
        n_page     = r_page;
        n_mask     = r_mask;
        n_used     = r_used;
        n_kind     = r_kind;
        n_pool     = r_pool;
        n_status   = r_status;
        n_rtype    = r_rtype;
        n_ridx     = r_ridx;
        n_newid    = r_newid;
        n_ctx      = r_ctx;
        n_slot     = r_slot;
        n_single   = r_single;
        n_k        = r_k;
        n_rem      = r_rem;
        n_sn       = r_sn;
        n_dcnt     = r_dcnt;
        n_cp       = r_cp;
        n_cfg_pool = r_cfg_pool;
        n_ovalid   = r_ovalid && i_out_stall;
        n_ostatus  = r_ostatus;
        n_otype    = r_otype;
        n_oidx     = r_oidx;
        n_onewid   = r_onewid;
        n_oalloc   = r_oalloc;
        n_ocap     = r_ocap;
        s_we       = 1'b0;
        s_wa       = '0;
        s_wd       = '0;
        rs_we      = 1'b0;
        rs_wa      = '0;
        rs_wd      = '0;
        push_en    = 1'b0;
        push_s     = 1'b0;
        push_idx   = '0;
        drop_en    = 1'b0;
        dp         = '0;
        advance    = 1'b0;
        v32        = '0;
        t32        = '0;
        dt         = '0;
        dd         = '0;
        sc8        = '0;
        rem_dec    = '0;

        // active slots of valid contexts
        slot_en = '0;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            for (int s = 0; s < MAX_SLOTS; s++) begin
                slot_en[c*MAX_SLOTS + s] = r_cv[c] && (SNW'(s) < r_cslots[c])
                                           && r_active[c*MAX_SLOTS + s];
            end
        end
        act_cnt = RMW'($countones(slot_en));

        ci_hit = 1'b0;
        ci_idx = '0;
        cf_hit = 1'b0;
        cf_idx = '0;
        for (int c = NUM_CONTEXTS - 1; c >= 0; c--) begin
            if (r_cv[c] && (r_cid[c] == i_context_id)) begin
                ci_hit = 1'b1;
                ci_idx = CW'(c);
            end
            if (!r_cv[c]) begin
                cf_hit = 1'b1;
                cf_idx = CW'(c);
            end
        end

        pf_hit = 1'b0;
        pf_idx = '0;
        ak_hit = 1'b0;
        ak_idx = '0;
        for (int p = PENDING_DEPTH - 1; p >= 0; p--) begin
            if (!r_pv[p]) begin
                pf_hit = 1'b1;
                pf_idx = PW'(p);
            end
            if (r_pv[p] && (UW'(r_page[p]) == r_k)) begin
                ak_hit = 1'b1;
                ak_idx = PW'(p);
            end
        end

        gs = GSW'(32'(r_ctx) * MAX_SLOTS + 32'(r_slot));

        unique case (r_state)
            dia_pkg::S_IDLE: begin
                if (cfg_acc) begin
                    n_cp = '0;
                    n_state = dia_pkg::S_CFG;
                    if (i_cfg_index == dia_pkg::CFG_SAMPLER_CAP) begin
                        v32 = 32'(i_cfg_data[11:0]);
                        if (v32 < 32'd1) v32 = 32'd1;
                        if (v32 > 32'(SAMPLER_POOL_MAX)) v32 = 32'(SAMPLER_POOL_MAX);
                        n_scap = SCW'(v32);
                        n_sdepth = SCW'(v32);
                        n_slow = SCW'(v32);
                        n_cfg_pool = dia_pkg::POOL_SAMPLER;
                    end else begin
                        v32 = 32'(i_cfg_data[12:0]);
                        if (v32 < 32'd1) v32 = 32'd1;
                        if (v32 > 32'(RESOURCE_POOL_MAX)) v32 = 32'(RESOURCE_POOL_MAX);
                        n_rcap = RCW'(v32);
                        n_rdepth = RCW'(v32);
                        n_rlow = RCW'(v32);
                        n_cfg_pool = dia_pkg::POOL_RESOURCE;
                    end
                end else if (in_acc) begin
                    n_kind   = i_kind;
                    n_status = dia_pkg::ST_OK;
                    n_rtype  = dia_pkg::BT_NONE;
                    n_ridx   = '0;
                    n_newid  = '0;
                    n_state  = dia_pkg::S_DONE;
                    unique case (i_kind)
                        dia_pkg::KIND_BIND: begin
                            if (i_view_kind == dia_pkg::VIEW_SAMPLER) begin
                                if (r_sdepth == '0) begin
                                    n_status = dia_pkg::ST_EXHAUSTED;
                                end else begin
                                    n_pool = dia_pkg::POOL_SAMPLER;
                                    n_rtype = dia_pkg::BT_SAMPLER;
                                    n_state = dia_pkg::S_POP;
                                end
                            end else if (i_view_kind <= dia_pkg::VIEW_IMAGE_UAV) begin
                                if (r_rdepth == '0) begin
                                    n_status = dia_pkg::ST_EXHAUSTED;
                                end else begin
                                    n_pool = dia_pkg::POOL_RESOURCE;
                                    n_rtype = i_view_kind + 3'd1;
                                    n_state = dia_pkg::S_POP;
                                end
                            end
                        end
                        dia_pkg::KIND_UNBIND: begin
                            if ((i_binding_type >= dia_pkg::BT_SAMPLER) &&
                                (i_binding_type <= dia_pkg::BT_STORAGE_IMAGE)) begin
                                if (act_cnt == '0) begin
                                    push_en = 1'b1;
                                    push_s = (i_binding_type == dia_pkg::BT_SAMPLER);
                                    push_idx = i_binding_index;
                                end else if (!pf_hit) begin
                                    n_status = dia_pkg::ST_PENDING_FULL;
                                end else begin
                                    n_pv[pf_idx] = 1'b1;
                                    n_pbt[pf_idx] = i_binding_type;
                                    n_pidx[pf_idx] = i_binding_index;
                                    n_prem[pf_idx] = act_cnt;
                                    n_page[pf_idx] = PW'(r_used);
                                    n_used = r_used + UW'(1);
                                    for (int g = 0; g < TS; g++) begin
                                        if (slot_en[g]) n_mask[g][pf_idx] = 1'b1;
                                    end
                                end
                            end
                        end
                        dia_pkg::KIND_REGISTER: begin
                            if (!cf_hit) begin
                                n_status = dia_pkg::ST_CONTEXTS_FULL;
                            end else begin
                                sc8 = i_slot_count;
                                if (sc8 < 8'd1) sc8 = 8'd1;
                                if (32'(sc8) > 32'(MAX_SLOTS)) sc8 = 8'(MAX_SLOTS);
                                n_newid = r_next_id;
                                n_next_id = r_next_id + 16'd1;
                                n_cv[cf_idx] = 1'b1;
                                n_cid[cf_idx] = r_next_id;
                                n_cslots[cf_idx] = SNW'(sc8);
                                for (int s = 0; s < MAX_SLOTS; s++) begin
                                    n_active[32'(cf_idx)*MAX_SLOTS + s] = 1'b0;
                                    n_mask[32'(cf_idx)*MAX_SLOTS + s] = '0;
                                end
                            end
                        end
                        dia_pkg::KIND_UNREGISTER, dia_pkg::KIND_BEGIN,
                        dia_pkg::KIND_RETIRE, dia_pkg::KIND_FLUSH: begin
                            if (!ci_hit) begin
                                n_status = dia_pkg::ST_UNKNOWN_CTX;
                            end else begin
                                n_ctx = ci_idx;
                                if ((i_kind == dia_pkg::KIND_BEGIN) ||
                                    (i_kind == dia_pkg::KIND_RETIRE)) begin
                                    n_rem = '0;
                                    n_sn = i_slot_number;
                                    n_dcnt = '0;
                                    n_state = dia_pkg::S_DIV;
                                end else begin
                                    n_slot = '0;
                                    n_single = 1'b0;
                                    n_state = dia_pkg::S_SLOT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dia_pkg::S_POP: begin
                if (r_pool == dia_pkg::POOL_SAMPLER) begin
                    if (r_sdepth == r_slow) begin
                        t32 = 32'(r_scap) - 32'(r_sdepth);
                        n_slow = r_slow - SCW'(1);
                    end else begin
                        t32 = 32'(r_srd);
                    end
                    n_sdepth = r_sdepth - SCW'(1);
                end else begin
                    if (r_rdepth == r_rlow) begin
                        t32 = 32'(r_rcap) - 32'(r_rdepth);
                        n_rlow = r_rlow - RCW'(1);
                    end else begin
                        t32 = 32'(r_rrd);
                    end
                    n_rdepth = r_rdepth - RCW'(1);
                end
                n_ridx = t32[11:0];
                n_state = dia_pkg::S_DONE;
            end
            dia_pkg::S_DIV: begin
                dd = r_cslots[r_ctx];
                dt = {r_rem, r_sn[7]};
                if (dt >= {1'b0, dd}) dt = dt - {1'b0, dd};
                n_rem = dt[SNW-1:0];
                n_sn = {r_sn[6:0], 1'b0};
                n_dcnt = r_dcnt + 3'd1;
                if (r_dcnt == 3'd7) begin
                    if (r_kind == dia_pkg::KIND_BEGIN) begin
                        gs = GSW'(32'(r_ctx) * MAX_SLOTS + 32'(dt[SNW-1:0]));
                        if (r_active[gs]) n_status = dia_pkg::ST_SLOT_ACTIVE;
                        else n_active[gs] = 1'b1;
                        n_state = dia_pkg::S_DONE;
                    end else begin
                        n_slot = SW'(dt[SNW-1:0]);
                        n_single = 1'b1;
                        n_state = dia_pkg::S_SLOT;
                    end
                end
            end
            dia_pkg::S_SLOT: begin
                if (r_active[gs]) begin
                    n_active[gs] = 1'b0;
                    n_k = '0;
                    n_state = dia_pkg::S_WALK;
                end else begin
                    advance = 1'b1;
                end
            end
            dia_pkg::S_WALK: begin
                if (r_k >= r_used) begin
                    advance = 1'b1;
                end else if (ak_hit && r_mask[gs][ak_idx]) begin
                    n_mask[gs][ak_idx] = 1'b0;
                    rem_dec = (r_prem[ak_idx] != '0) ? r_prem[ak_idx] - RMW'(1) : '0;
                    n_prem[ak_idx] = rem_dec;
                    if (rem_dec == '0) begin
                        push_en = 1'b1;
                        push_s = (r_pbt[ak_idx] == dia_pkg::BT_SAMPLER);
                        push_idx = r_pidx[ak_idx];
                        drop_en = 1'b1;
                        dp = ak_idx;
                    end else begin
                        n_k = r_k + UW'(1);
                    end
                end else begin
                    n_k = r_k + UW'(1);
                end
            end
            dia_pkg::S_CFG: begin
                if (r_pv[r_cp] &&
                    ((r_pbt[r_cp] == dia_pkg::BT_SAMPLER) ? dia_pkg::POOL_SAMPLER
                                                          : dia_pkg::POOL_RESOURCE)
                    == r_cfg_pool) begin
                    drop_en = 1'b1;
                    dp = r_cp;
                end
                n_cp = r_cp + PW'(1);
                if (32'(r_cp) == PENDING_DEPTH - 1) n_state = dia_pkg::S_IDLE;
            end
            dia_pkg::S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_ostatus = r_status;
                    n_otype = r_rtype;
                    n_oidx = r_ridx;
                    n_onewid = r_newid;
                    t32 = (32'(r_scap) - 32'(r_sdepth)) + (32'(r_rcap) - 32'(r_rdepth));
                    n_oalloc = t32[12:0];
                    t32 = 32'(r_scap) + 32'(r_rcap);
                    n_ocap = t32[12:0];
                    n_state = dia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dia_pkg::S_IDLE;
            end
        endcase

        // move to the next slot of an unregister, flush or retire
        if (advance) begin
            if (r_single || (32'(r_slot) + 1 >= 32'(r_cslots[r_ctx]))) begin
                if (r_kind == dia_pkg::KIND_UNREGISTER) n_cv[r_ctx] = 1'b0;
                n_state = dia_pkg::S_DONE;
            end else begin
                n_slot = r_slot + SW'(1);
                n_state = dia_pkg::S_SLOT;
            end
        end

        // push a released index
        if (push_en) begin
            if (push_s) begin
                if ((32'(push_idx) < 32'(r_scap)) && (r_sdepth < r_scap)) begin
                    s_we = 1'b1;
                    s_wa = SAW'(r_sdepth);
                    s_wd = SAW'(push_idx);
                    n_sdepth = r_sdepth + SCW'(1);
                end
            end else begin
                if ((32'(push_idx) < 32'(r_rcap)) && (r_rdepth < r_rcap)) begin
                    rs_we = 1'b1;
                    rs_wa = RAW'(r_rdepth);
                    rs_wd = RAW'(push_idx);
                    n_rdepth = r_rdepth + RCW'(1);
                end
            end
        end

        // drop a pending entry and close the age gap
        if (drop_en) begin
            n_pv[dp] = 1'b0;
            for (int p = 0; p < PENDING_DEPTH; p++) begin
                if (r_pv[p] && (r_page[p] > r_page[dp])) n_page[p] = r_page[p] - PW'(1);
            end
            for (int g = 0; g < TS; g++) begin
                n_mask[g][dp] = 1'b0;
            end
            if (r_used != '0) n_used = r_used - UW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dia_pkg::S_IDLE;
            r_scap    <= SCW'(SAMPLER_POOL_MAX);
            r_sdepth  <= SCW'(SAMPLER_POOL_MAX);
            r_slow    <= SCW'(SAMPLER_POOL_MAX);
            r_rcap    <= RCW'(RESOURCE_POOL_MAX);
            r_rdepth  <= RCW'(RESOURCE_POOL_MAX);
            r_rlow    <= RCW'(RESOURCE_POOL_MAX);
            r_active  <= '0;
            r_next_id <= '0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                r_cv[c] <= 1'b0;
            end
            for (int p = 0; p < PENDING_DEPTH; p++) begin
                r_pv[p] <= 1'b0;
            end
            for (int g = 0; g < TS; g++) begin
                r_mask[g] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_scap    <= n_scap;
            r_sdepth  <= n_sdepth;
            r_slow    <= n_slow;
            r_rcap    <= n_rcap;
            r_rdepth  <= n_rdepth;
            r_rlow    <= n_rlow;
            r_active  <= n_active;
            r_next_id <= n_next_id;
            r_used    <= n_used;
            r_ovalid  <= n_ovalid;
            r_cv      <= n_cv;
            r_pv      <= n_pv;
            r_mask    <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cid      <= n_cid;
        r_cslots   <= n_cslots;
        r_pbt      <= n_pbt;
        r_pidx     <= n_pidx;
        r_prem     <= n_prem;
        r_page     <= n_page;
        r_kind     <= n_kind;
        r_pool     <= n_pool;
        r_status   <= n_status;
        r_rtype    <= n_rtype;
        r_ridx     <= n_ridx;
        r_newid    <= n_newid;
        r_ctx      <= n_ctx;
        r_slot     <= n_slot;
        r_single   <= n_single;
        r_k        <= n_k;
        r_rem      <= n_rem;
        r_sn       <= n_sn;
        r_dcnt     <= n_dcnt;
        r_cp       <= n_cp;
        r_cfg_pool <= n_cfg_pool;
        r_ostatus  <= n_ostatus;
        r_otype    <= n_otype;
        r_oidx     <= n_oidx;
        r_onewid   <= n_onewid;
        r_oalloc   <= n_oalloc;
        r_ocap     <= n_ocap;
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_ostatus;
    assign o_result_type     = r_otype;
    assign o_result_index    = r_oidx;
    assign o_new_context_id  = r_onewid;
    assign o_allocated_total = r_oalloc;
    assign o_capacity_total  = r_ocap;

    logic [PENDING_DEPTH-1:0] pv_vec;
    always_comb begin
        for (int p = 0; p < PENDING_DEPTH; p++) begin
            pv_vec[p] = r_pv[p];
        end
    end

    a_sdepth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sdepth <= r_scap) && (r_rdepth <= r_rcap))
        else $error("stack depth above capacity");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slow <= r_sdepth) && (r_rlow <= r_rdepth))
        else $error("low-water mark above stack depth");

    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(pv_vec) == 32'(r_used))
        else $error("pending count out of step with valid entries");

    a_pop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dia_pkg::S_POP) |=> (r_state == dia_pkg::S_DONE))
        else $error("pop did not complete");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import dia_pkg::*;

    localparam int TOTAL_SLOTS = NUM_CONTEXTS * MAX_SLOTS;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE      = 200;
    localparam int HOLD_LEN    = 300;
    localparam int RAND_PER_PHASE = 110;

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  view;
        logic [2:0]  btype;
        logic [11:0] bidx;
        logic [15:0] cid;
        logic [7:0]  slot;
        logic [7:0]  nslots;
    } req_t;

    typedef struct {
        logic [2:0]  status;
        logic [2:0]  rtype;
        logic [11:0] ridx;
        logic [15:0] newid;
        logic [12:0] alloc;
        logic [12:0] cap;
    } rsp_t;

    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t e;
    } row_t;

    typedef struct {
        bit          ok;
        logic [15:0] id;
        int          slots;
    } ctx_t;

    typedef struct {
        bit         ok;
        logic [2:0] btype;
        logic [11:0] idx;
        int         rem;
        int         age;
    } rel_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [2:0]          i_kind = '0;
    logic [2:0]          i_view_kind = '0;
    logic [2:0]          i_binding_type = '0;
    logic [11:0]         i_binding_index = '0;
    logic [15:0]         i_context_id = '0;
    logic [7:0]          i_slot_number = '0;
    logic [7:0]          i_slot_count = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [2:0]          o_status;
    logic [2:0]          o_result_type;
    logic [11:0]         o_result_index;
    logic [15:0]         o_new_context_id;
    logic [12:0]         o_allocated_total;
    logic [12:0]         o_capacity_total;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;

    descriptor_index_allocator_deferred_free_unit i_dut (.*);

    always #1 i_clk = ~i_clk;

    // allocator state mirror
    logic [10:0] smp_free[SAMPLER_POOL_MAX];
    logic [11:0] res_free[RESOURCE_POOL_MAX];
    int          smp_depth, res_depth, smp_cap, res_cap;
    ctx_t        ctx_tab[NUM_CONTEXTS];
    bit          slot_on[TOTAL_SLOTS];
    rel_t        rel_tab[PENDING_DEPTH];
    bit          rel_mask[TOTAL_SLOTS][PENDING_DEPTH];
    int          rel_used;
    logic [15:0] id_ctr;

    rsp_t rsp_q[$];
    row_t dir_q[$];
    int   n_mis = 0;
    bit   hold_go = 1'b0;

    function automatic void refill_sampler(int cap);
        for (int i = 0; i < cap; i++) smp_free[i] = 11'(cap - 1 - i);
        smp_depth = cap;
    endfunction

    function automatic void refill_resource(int cap);
        for (int i = 0; i < cap; i++) res_free[i] = 12'(cap - 1 - i);
        res_depth = cap;
    endfunction

    function automatic void give_back(logic [2:0] bt, logic [11:0] idx);
        if (bt == BT_SAMPLER) begin
            if (idx < smp_cap && smp_depth < smp_cap) begin
                smp_free[smp_depth] = idx[10:0];
                smp_depth++;
            end
        end else begin
            if (idx < res_cap && res_depth < res_cap) begin
                res_free[res_depth] = idx;
                res_depth++;
            end
        end
    endfunction

    function automatic void drop_release(int p);
        int a;
        a = rel_tab[p].age;
        rel_tab[p].ok = 1'b0;
        for (int i = 0; i < PENDING_DEPTH; i++)
            if (rel_tab[i].ok && rel_tab[i].age > a) rel_tab[i].age--;
        for (int i = 0; i < TOTAL_SLOTS; i++) rel_mask[i][p] = 1'b0;
        if (rel_used > 0) rel_used--;
    endfunction

    function automatic void drop_pool_releases(logic pool);
        for (int p = 0; p < PENDING_DEPTH; p++)
            if (rel_tab[p].ok && ((rel_tab[p].btype == BT_SAMPLER) ? POOL_SAMPLER
                                                                    : POOL_RESOURCE) == pool)
                drop_release(p);
    endfunction

    function automatic void reset_state();
        smp_cap = SAMPLER_POOL_MAX;
        res_cap = RESOURCE_POOL_MAX;
        refill_sampler(smp_cap);
        refill_resource(res_cap);
        for (int c = 0; c < NUM_CONTEXTS; c++) ctx_tab[c] = '{1'b0, 16'd0, 0};
        for (int s = 0; s < TOTAL_SLOTS; s++) begin
            slot_on[s] = 1'b0;
            for (int p = 0; p < PENDING_DEPTH; p++) rel_mask[s][p] = 1'b0;
        end
        for (int p = 0; p < PENDING_DEPTH; p++) rel_tab[p] = '{1'b0, 3'd0, 12'd0, 0, 0};
        rel_used = 0;
        id_ctr = '0;
    endfunction

    function automatic void write_cap(logic idx, logic [CFG_DW-1:0] data);
        int v;
        if (idx == CFG_SAMPLER_CAP) begin
            v = int'(data[11:0]);
            if (v < 1) v = 1;
            if (v > SAMPLER_POOL_MAX) v = SAMPLER_POOL_MAX;
            smp_cap = v;
            refill_sampler(v);
            drop_pool_releases(POOL_SAMPLER);
        end else begin
            v = int'(data[12:0]);
            if (v < 1) v = 1;
            if (v > RESOURCE_POOL_MAX) v = RESOURCE_POOL_MAX;
            res_cap = v;
            refill_resource(v);
            drop_pool_releases(POOL_RESOURCE);
        end
    endfunction

    function automatic int lookup_ctx(logic [15:0] id);
        for (int c = 0; c < NUM_CONTEXTS; c++)
            if (ctx_tab[c].ok && ctx_tab[c].id == id) return c;
        return -1;
    endfunction

    function automatic void retire_slot(int c, int s);
        int gs, k, p;
        bit hit;
        gs = c * MAX_SLOTS + s;
        k = 0;
        if (!slot_on[gs]) return;
        slot_on[gs] = 1'b0;
        while (k < rel_used) begin
            hit = 1'b0;
            for (p = 0; p < PENDING_DEPTH; p++)
                if (rel_tab[p].ok && rel_tab[p].age == k) begin
                    hit = 1'b1;
                    break;
                end
            if (hit && rel_mask[gs][p]) begin
                rel_mask[gs][p] = 1'b0;
                if (rel_tab[p].rem > 0) rel_tab[p].rem--;
                if (rel_tab[p].rem == 0) begin
                    give_back(rel_tab[p].btype, rel_tab[p].idx);
                    drop_release(p);
                    continue;
                end
            end
            k++;
        end
    endfunction

    function automatic rsp_t predict_alloc(req_t r);
        rsp_t o;
        int ci, c, s, p, active, sc;
        o = '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd0, 13'd0};
        ci = lookup_ctx(r.cid);
        case (r.kind)
            KIND_BIND: begin
                if (r.view == VIEW_SAMPLER) begin
                    if (smp_depth == 0) o.status = ST_EXHAUSTED;
                    else begin
                        smp_depth--;
                        o.rtype = BT_SAMPLER;
                        o.ridx = 12'(smp_free[smp_depth]);
                    end
                end else if (r.view <= VIEW_IMAGE_UAV) begin
                    if (res_depth == 0) o.status = ST_EXHAUSTED;
                    else begin
                        res_depth--;
                        o.rtype = r.view + 3'd1;
                        o.ridx = res_free[res_depth];
                    end
                end
            end
            KIND_UNBIND: begin
                if (r.btype >= BT_SAMPLER && r.btype <= BT_STORAGE_IMAGE) begin
                    active = 0;
                    for (c = 0; c < NUM_CONTEXTS; c++)
                        if (ctx_tab[c].ok)
                            for (s = 0; s < ctx_tab[c].slots; s++)
                                if (slot_on[c * MAX_SLOTS + s]) active++;
                    if (active == 0) give_back(r.btype, r.bidx);
                    else begin
                        for (p = 0; p < PENDING_DEPTH; p++)
                            if (!rel_tab[p].ok) break;
                        if (p >= PENDING_DEPTH) o.status = ST_PENDING_FULL;
                        else begin
                            rel_tab[p] = '{1'b1, r.btype, r.bidx, active, rel_used};
                            rel_used++;
                            for (c = 0; c < NUM_CONTEXTS; c++)
                                if (ctx_tab[c].ok)
                                    for (s = 0; s < ctx_tab[c].slots; s++)
                                        if (slot_on[c * MAX_SLOTS + s])
                                            rel_mask[c * MAX_SLOTS + s][p] = 1'b1;
                        end
                    end
                end
            end
            KIND_REGISTER: begin
                for (c = 0; c < NUM_CONTEXTS; c++)
                    if (!ctx_tab[c].ok) break;
                if (c >= NUM_CONTEXTS) o.status = ST_CONTEXTS_FULL;
                else begin
                    sc = int'(r.nslots);
                    if (sc < 1) sc = 1;
                    if (sc > MAX_SLOTS) sc = MAX_SLOTS;
                    o.newid = id_ctr;
                    id_ctr = id_ctr + 16'd1;
                    ctx_tab[c] = '{1'b1, o.newid, sc};
                    for (s = 0; s < MAX_SLOTS; s++) begin
                        slot_on[c * MAX_SLOTS + s] = 1'b0;
                        for (p = 0; p < PENDING_DEPTH; p++) rel_mask[c * MAX_SLOTS + s][p] = 1'b0;
                    end
                end
            end
            KIND_UNREGISTER, KIND_BEGIN, KIND_RETIRE, KIND_FLUSH: begin
                if (ci < 0) o.status = ST_UNKNOWN_CTX;
                else begin
                    s = int'(r.slot) % ctx_tab[ci].slots;
                    if (r.kind == KIND_BEGIN) begin
                        if (slot_on[ci * MAX_SLOTS + s]) o.status = ST_SLOT_ACTIVE;
                        else slot_on[ci * MAX_SLOTS + s] = 1'b1;
                    end else if (r.kind == KIND_RETIRE) begin
                        retire_slot(ci, s);
                    end else begin
                        for (s = 0; s < ctx_tab[ci].slots; s++) retire_slot(ci, s);
                        if (r.kind == KIND_UNREGISTER) ctx_tab[ci].ok = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        o.alloc = 13'((smp_cap - smp_depth) + (res_cap - res_depth));
        o.cap = 13'(smp_cap + res_cap);
        return o;
    endfunction

    function automatic req_t mk(logic [2:0] kind, logic [2:0] view, logic [2:0] bt,
                                logic [11:0] bi, logic [15:0] cid, logic [7:0] sn,
                                logic [7:0] sc);
        req_t r;
        r = '{kind, view, bt, bi, cid, sn, sc};
        return r;
    endfunction

    function automatic void add(req_t r, bit fixed = 1'b0, rsp_t e = '{3'd0, 3'd0, 12'd0,
                                16'd0, 13'd0, 13'd0});
        row_t w;
        w.r = r;
        w.fixed = fixed;
        w.e = e;
        dir_q.push_back(w);
    endfunction

    function automatic req_t random_req();
        req_t r;
        int pick, n;
        logic [15:0] ids[$];
        r.kind   = 3'($urandom_range(0, 7));
        r.view   = 3'($urandom);
        r.btype  = 3'($urandom);
        r.bidx   = 12'($urandom);
        r.cid    = 16'($urandom);
        r.slot   = 8'($urandom);
        r.nslots = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) r.kind = KIND_BIND;
        else if (pick < 55) r.kind = KIND_UNBIND;
        else if (pick < 63) r.kind = KIND_REGISTER;
        else if (pick < 68) r.kind = KIND_UNREGISTER;
        else if (pick < 81) r.kind = KIND_BEGIN;
        else if (pick < 93) r.kind = KIND_RETIRE;
        else if (pick < 96) r.kind = KIND_FLUSH;
        else r.kind = KIND_STATS;
        if (r.kind == KIND_BIND && $urandom_range(0, 9) != 0)
            r.view = 3'($urandom_range(0, 3));
        if (r.kind == KIND_UNBIND) begin
            if ($urandom_range(0, 9) != 0) r.btype = 3'($urandom_range(1, 4));
            n = (r.btype == BT_SAMPLER) ? smp_cap : res_cap;
            if ($urandom_range(0, 4) != 0) r.bidx = 12'($urandom_range(0, n - 1));
        end
        for (int c = 0; c < NUM_CONTEXTS; c++)
            if (ctx_tab[c].ok) ids.push_back(ctx_tab[c].id);
        if (ids.size() > 0 && $urandom_range(0, 99) < 85)
            r.cid = ids[$urandom_range(0, ids.size() - 1)];
        return r;
    endfunction

    // request driver
    int burst_left = 1;

    task automatic send(req_t r, bit fixed, rsp_t e);
        rsp_t p;
        int gap;
        i_kind          <= r.kind;
        i_view_kind     <= r.view;
        i_binding_type  <= r.btype;
        i_binding_index <= r.bidx;
        i_context_id    <= r.cid;
        i_slot_number   <= r.slot;
        i_slot_count    <= r.nslots;
        i_in_valid      <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        p = predict_alloc(r);
        rsp_q.push_back(fixed ? e : p);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic set_caps(logic [CFG_DW-1:0] sc, logic [CFG_DW-1:0] rc);
        i_in_valid <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_q.size() == 0) break;
        end
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SAMPLER_CAP;
        i_cfg_data  <= sc;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        write_cap(CFG_SAMPLER_CAP, sc);
        i_cfg_index <= CFG_RESOURCE_CAP;
        i_cfg_data  <= rc;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        write_cap(CFG_RESOURCE_CAP, rc);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern
    int seg_left = 0, seg_mode = 0, seg_per = 4, hold_cnt = 0, rx_cyc = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        logic st;
        rx_cyc++;
        if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 2);
            seg_per = $urandom_range(2, 9);
            seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (seg_mode)
            0: st = 1'b0;
            1: st = ($urandom_range(0, 9) < 4);
            default: st = ((rx_cyc % seg_per) < seg_per / 2);
        endcase
        if (hold_go && !hold_done) begin
            st = 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
        end
        i_out_stall <= st;
    end

    // result check
    always @(posedge i_clk) begin
        rsp_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_q.size() == 0) begin
                if (n_mis < 10) $display("unexpected result status=%0d", o_status);
                n_mis++;
            end else begin
                e = rsp_q.pop_front();
                if (o_status !== e.status || o_result_type !== e.rtype ||
                    o_result_index !== e.ridx || o_new_context_id !== e.newid ||
                    o_allocated_total !== e.alloc || o_capacity_total !== e.cap) begin
                    if (n_mis < 10)
                        $display({"mismatch: exp st=%0d ty=%0d ix=%0d id=%0d al=%0d cap=%0d",
                                  " got st=%0d ty=%0d ix=%0d id=%0d al=%0d cap=%0d"},
                                 e.status, e.rtype, e.ridx, e.newid, e.alloc, e.cap,
                                 o_status, o_result_type, o_result_index, o_new_context_id,
                                 o_allocated_total, o_capacity_total);
                    n_mis++;
                end
            end
        end
    end

    // watchdog on requests, results and register writes
    int idle_cyc = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    logic [CFG_DW-1:0] smp_set[6] = '{13'd0, 13'd4, 13'h1FFF, 13'd2048, 13'd1, 13'd16};
    logic [CFG_DW-1:0] res_set[6] = '{13'd0, 13'd3, 13'h1FFF, 13'd1, 13'd4096, 13'd24};

    initial begin
        reset_state();
        add(mk(KIND_BIND, VIEW_SAMPLER, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_OK, BT_SAMPLER, 12'd0, 16'd0, 13'd1, 13'd6144});
        add(mk(KIND_BIND, 3'd1, 3'd7, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF), 1'b1,
            '{ST_OK, 3'd2, 12'd0, 16'd0, 13'd2, 13'd6144});
        add(mk(KIND_BIND, VIEW_IMAGE_UAV, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_OK, BT_STORAGE_IMAGE, 12'd1, 16'd0, 13'd3, 13'd6144});
        add(mk(KIND_BIND, 3'd7, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd3, 13'd6144});
        add(mk(KIND_STATS, 3'd7, 3'd7, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd3, 13'd6144});
        add(mk(KIND_UNBIND, 3'd0, BT_NONE, 12'd1, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd3, 13'd6144});
        add(mk(KIND_UNBIND, 3'd0, BT_SAMPLER, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd2, 13'd6144});
        add(mk(KIND_BEGIN, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_UNKNOWN_CTX, BT_NONE, 12'd0, 16'd0, 13'd2, 13'd6144});
        add(mk(KIND_REGISTER, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd2, 13'd6144});
        add(mk(KIND_REGISTER, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'hFF), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd1, 13'd2, 13'd6144});
        add(mk(KIND_BEGIN, 3'd0, 3'd0, 12'd0, 16'd0, 8'hFF, 8'd0), 1'b1,
            '{ST_OK, BT_NONE, 12'd0, 16'd0, 13'd2, 13'd6144});
        add(mk(KIND_BEGIN, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0), 1'b1,
            '{ST_SLOT_ACTIVE, BT_NONE, 12'd0, 16'd0, 13'd2, 13'd6144});
        add(mk(KIND_UNBIND, 3'd0, 3'd2, 12'd0, 16'd0, 8'd0, 8'd0));
        add(mk(KIND_UNBIND, 3'd0, BT_STORAGE_IMAGE, 12'hFFF, 16'd0, 8'd0, 8'd0));
        add(mk(KIND_BEGIN, 3'd0, 3'd0, 12'd0, 16'd1, 8'd6, 8'd0));
        add(mk(KIND_UNBIND, 3'd0, 3'd3, 12'd1, 16'd0, 8'd0, 8'd0));
        add(mk(KIND_RETIRE, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd0));
        add(mk(KIND_RETIRE, 3'd0, 3'd0, 12'd0, 16'd1, 8'd1, 8'd0));
        add(mk(KIND_FLUSH, 3'd0, 3'd0, 12'd0, 16'd1, 8'd0, 8'd0));
        add(mk(KIND_REGISTER, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd3));
        add(mk(KIND_REGISTER, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd4));
        add(mk(KIND_REGISTER, 3'd0, 3'd0, 12'd0, 16'd0, 8'd0, 8'd2));
        add(mk(KIND_UNREGISTER, 3'd0, 3'd0, 12'd0, 16'd2, 8'd0, 8'd0));
        add(mk(KIND_FLUSH, 3'd0, 3'd0, 12'd0, 16'd999, 8'd0, 8'd0));
        add(mk(KIND_UNREGISTER, 3'd0, 3'd0, 12'd0, 16'hFFFF, 8'd0, 8'd0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_q[i]) send(dir_q[i].r, dir_q[i].fixed, dir_q[i].e);

        for (int ph = 0; ph < 6; ph++) begin
            set_caps(smp_set[ph], res_set[ph]);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 1 && n == 10) hold_go <= 1'b1;
                send(random_req(), 1'b0, '{3'd0, 3'd0, 12'd0, 16'd0, 13'd0, 13'd0});
            end
        end
        i_in_valid <= 1'b0;

        forever begin
            @(posedge i_clk);
            if (rsp_q.size() == 0) break;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (n_mis == 0 && rsp_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: descriptor_index_allocator_deferred_free_unit.f
sv/dia_pkg.sv
sv/descriptor_index_allocator_deferred_free_unit.sv
verif/tb.sv
